FILE: rtl/att_pkg.sv
// Shared types, constants and helper functions for the allocation tracker table.
package att_pkg;

  // Table geometry
  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);

  // Field widths
  localparam int unsigned AddrW  = 48;
  localparam int unsigned SizeW  = 32;
  localparam int unsigned CallW  = 32;
  localparam int unsigned BytesW = 48;

  // Opcode values
  localparam logic OpAlloc   = 1'b0;
  localparam logic OpRelease = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_REUSED  = 3'd1,
    ST_FULL    = 3'd2,
    ST_REL_OK  = 3'd3,
    ST_NULL    = 3'd4,
    ST_DOUBLE  = 3'd5,
    ST_UNKNOWN = 3'd6
  } att_status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } att_state_e;

  // Input transaction payload
  typedef struct packed {
    logic              opcode;
    logic [AddrW-1:0]  address;
    logic [SizeW-1:0]  size_bytes;
  } att_in_t;

  // Output transaction payload
  typedef struct packed {
    logic [2:0]        status;
    logic [CallW-1:0]  alloc_calls;
    logic [CallW-1:0]  release_ok_calls;
    logic [CallW-1:0]  release_failed_calls;
    logic [BytesW-1:0] bytes_allocated;
    logic [BytesW-1:0] bytes_released;
  } att_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;    // latch new item, restart the scan
    logic scan_en;  // step the table scan
    logic update;   // commit table/counter update and load the result
  } att_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;       // compared entry matches the item address
    logic miss;      // scan exhausted with no match
    logic null_rel;  // release of address zero
  } att_sts_t;

  // Saturating increment of a call counter
  function automatic logic [CallW-1:0] sat_inc(input logic [CallW-1:0] v);
    logic [CallW:0] s;
    s = {1'b0, v} + {{CallW{1'b0}}, 1'b1};
    return s[CallW] ? {CallW{1'b1}} : s[CallW-1:0];
  endfunction

  // Saturating add of a size to a byte total
  function automatic logic [BytesW-1:0] sat_add(input logic [BytesW-1:0] total,
                                                 input logic [SizeW-1:0]  add);
    logic [BytesW:0] s;
    s = {1'b0, total} + {{(BytesW - SizeW + 1){1'b0}}, add};
    return s[BytesW] ? {BytesW{1'b1}} : s[BytesW-1:0];
  endfunction

endpackage

FILE: rtl/att_ctrl.sv
// Controller state machine: sequences accept, table scan, update and result hand-off.
module att_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  att_pkg::att_sts_t sts_i,
  output att_pkg::att_cmd_t cmd_o
);

  att_pkg::att_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;
  logic                out_free;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= att_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != att_pkg::S_IDLE);
  assign accept      = in_valid_i && (state_q == att_pkg::S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.start   = accept;
    unique case (state_q)
      att_pkg::S_IDLE: begin
        if (accept) state_d = att_pkg::S_SCAN;
      end
      att_pkg::S_SCAN: begin
        if (sts_i.null_rel || sts_i.hit || sts_i.miss) begin
          state_d = att_pkg::S_UPDATE;
        end else begin
          cmd_o.scan_en = 1'b1;
        end
      end
      att_pkg::S_UPDATE: begin
        // hold the finished item until the result register is free
        if (out_free) begin
          cmd_o.update = 1'b1;
          state_d      = att_pkg::S_IDLE;
        end
      end
      default: state_d = att_pkg::S_IDLE;
    endcase
  end

  // Result valid: set on commit, cleared once the transaction is taken
  always_comb begin
    if (cmd_o.update) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

endmodule

FILE: rtl/att_datapath.sv
// Datapath: item register, entry table, scan pipeline, counters and result register.
module att_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  att_pkg::att_in_t  in_data_i,
  input  att_pkg::att_cmd_t cmd_i,
  output att_pkg::att_sts_t sts_o,
  output att_pkg::att_out_t out_data_o
);

  // Entry table storage
  logic [att_pkg::AddrW-1:0] addr_mem [att_pkg::TableDepth];
  logic [att_pkg::SizeW-1:0] size_mem [att_pkg::TableDepth];
  logic [att_pkg::TableDepth-1:0] live_q;

  att_pkg::att_in_t item_q;
  logic [att_pkg::CntW-1:0]   used_q;
  logic [att_pkg::CntW-1:0]   scan_idx_q;
  logic                       cmp_vld_q;
  logic [att_pkg::IdxW-1:0]   cmp_idx_q;
  logic [att_pkg::AddrW-1:0]  rd_addr_q;
  logic [att_pkg::SizeW-1:0]  rd_size_q;

  logic [att_pkg::CallW-1:0]  alloc_cnt_q, alloc_cnt_d;
  logic [att_pkg::CallW-1:0]  rel_ok_cnt_q, rel_ok_cnt_d;
  logic [att_pkg::CallW-1:0]  rel_fail_cnt_q, rel_fail_cnt_d;
  logic [att_pkg::BytesW-1:0] alloc_bytes_q, alloc_bytes_d;
  logic [att_pkg::BytesW-1:0] rel_bytes_q, rel_bytes_d;
  att_pkg::att_out_t          res_q;

  logic                     hit;
  logic                     issue;
  logic                     full;
  logic                     null_rel;
  logic [att_pkg::IdxW-1:0] new_idx;
  att_pkg::att_status_e     status;
  logic                     wr_new;
  logic                     wr_reuse;
  logic                     set_live;
  logic                     clr_live;

  assign hit      = cmp_vld_q && (rd_addr_q == item_q.address);
  assign issue    = cmd_i.scan_en && !hit && (scan_idx_q < used_q);
  assign full     = (used_q == att_pkg::CntW'(att_pkg::TableDepth));
  assign null_rel = (item_q.opcode == att_pkg::OpRelease) &&
                    (item_q.address == '0);
  assign new_idx  = used_q[att_pkg::IdxW-1:0];

  assign sts_o.hit      = hit;
  assign sts_o.miss     = !cmp_vld_q && (scan_idx_q >= used_q);
  assign sts_o.null_rel = null_rel;

  // Item register
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) item_q <= in_data_i;
  end

  // Scan pipeline control: one table read issued per cycle, compared the next
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      cmp_vld_q  <= 1'b0;
    end else if (cmd_i.start) begin
      scan_idx_q <= '0;
      cmp_vld_q  <= 1'b0;
    end else if (cmd_i.scan_en && !hit) begin
      cmp_vld_q <= issue;
      if (issue) scan_idx_q <= scan_idx_q + att_pkg::CntW'(1);
    end
  end

  // Table read port, registered
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_addr_q <= addr_mem[scan_idx_q[att_pkg::IdxW-1:0]];
      rd_size_q <= size_mem[scan_idx_q[att_pkg::IdxW-1:0]];
      cmp_idx_q <= scan_idx_q[att_pkg::IdxW-1:0];
    end
  end

  // Update decision and next counter values
  always_comb begin
    alloc_cnt_d    = alloc_cnt_q;
    rel_ok_cnt_d   = rel_ok_cnt_q;
    rel_fail_cnt_d = rel_fail_cnt_q;
    alloc_bytes_d  = alloc_bytes_q;
    rel_bytes_d    = rel_bytes_q;
    wr_new         = 1'b0;
    wr_reuse       = 1'b0;
    set_live       = 1'b0;
    clr_live       = 1'b0;
    status         = att_pkg::ST_NEW;
    if (item_q.opcode == att_pkg::OpAlloc) begin
      if (hit) begin
        wr_reuse      = 1'b1;
        alloc_cnt_d   = att_pkg::sat_inc(alloc_cnt_q);
        alloc_bytes_d = att_pkg::sat_add(alloc_bytes_q, item_q.size_bytes);
        status        = att_pkg::ST_REUSED;
      end else if (full) begin
        status = att_pkg::ST_FULL;
      end else begin
        wr_new        = 1'b1;
        alloc_cnt_d   = att_pkg::sat_inc(alloc_cnt_q);
        alloc_bytes_d = att_pkg::sat_add(alloc_bytes_q, item_q.size_bytes);
        status        = att_pkg::ST_NEW;
      end
      set_live = wr_new || wr_reuse;
    end else begin
      if (null_rel) begin
        rel_fail_cnt_d = att_pkg::sat_inc(rel_fail_cnt_q);
        status         = att_pkg::ST_NULL;
      end else if (!hit) begin
        rel_fail_cnt_d = att_pkg::sat_inc(rel_fail_cnt_q);
        status         = att_pkg::ST_UNKNOWN;
      end else if (!live_q[cmp_idx_q]) begin
        rel_fail_cnt_d = att_pkg::sat_inc(rel_fail_cnt_q);
        status         = att_pkg::ST_DOUBLE;
      end else begin
        clr_live     = 1'b1;
        rel_ok_cnt_d = att_pkg::sat_inc(rel_ok_cnt_q);
        rel_bytes_d  = att_pkg::sat_add(rel_bytes_q, rd_size_q);
        status       = att_pkg::ST_REL_OK;
      end
    end
  end

  // Table write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && wr_new) begin
      addr_mem[new_idx] <= item_q.address;
      size_mem[new_idx] <= item_q.size_bytes;
    end else if (cmd_i.update && wr_reuse) begin
      size_mem[cmp_idx_q] <= item_q.size_bytes;
    end
  end

  // Live bits, fill count and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q         <= '0;
      used_q         <= '0;
      alloc_cnt_q    <= '0;
      rel_ok_cnt_q   <= '0;
      rel_fail_cnt_q <= '0;
      alloc_bytes_q  <= '0;
      rel_bytes_q    <= '0;
    end else if (cmd_i.update) begin
      if (wr_new) begin
        live_q[new_idx] <= 1'b1;
        used_q          <= used_q + att_pkg::CntW'(1);
      end else if (set_live) begin
        live_q[cmp_idx_q] <= 1'b1;
      end else if (clr_live) begin
        live_q[cmp_idx_q] <= 1'b0;
      end
      alloc_cnt_q    <= alloc_cnt_d;
      rel_ok_cnt_q   <= rel_ok_cnt_d;
      rel_fail_cnt_q <= rel_fail_cnt_d;
      alloc_bytes_q  <= alloc_bytes_d;
      rel_bytes_q    <= rel_bytes_d;
    end
  end

  // Result register: status plus a snapshot of the updated counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      res_q.status               <= status;
      res_q.alloc_calls          <= alloc_cnt_d;
      res_q.release_ok_calls     <= rel_ok_cnt_d;
      res_q.release_failed_calls <= rel_fail_cnt_d;
      res_q.bytes_allocated      <= alloc_bytes_d;
      res_q.bytes_released       <= rel_bytes_d;
    end
  end

  assign out_data_o = res_q;

endmodule

FILE: rtl/allocation_tracker_table_unit.sv
// Allocation tracker table: top level joining the controller and the datapath.
// An accepted item is compared against the N entries in use (N at most 16), in order,
// until a hit or the end of the used entries; then the update is committed and the result
// loaded. A null release, or any item while the table is empty, reads no entry. The scan
// reads one entry per cycle. Items are handled one at a time; the next item is accepted in
// the cycle after the previous result is committed, and output stalls hold that commit.
// Reset: asynchronous active-low; clears live bits, fill count, counters and control.
module allocation_tracker_table_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  att_pkg::att_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output att_pkg::att_out_t out_data_o
);

  att_pkg::att_cmd_t cmd;
  att_pkg::att_sts_t sts;

  // Sequencer
  att_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Table, counters and result register
  att_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the allocation tracker table unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CycleLimit = 10_000_000;
  localparam int ReportCap = 100;
  localparam int LargePairs = 200;
  localparam int RandomEvents = 1500;
  localparam int DrainCycles = 40;
  localparam logic [att_pkg::AddrW-1:0] TopAddr = '1;
  localparam logic [att_pkg::AddrW-1:0] StrayAddr = 48'h1;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  att_pkg::att_in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  att_pkg::att_out_t out_data_o;

  // Shadow copy of the allocation table and its counters
  logic [att_pkg::AddrW-1:0]  tbl_addr [att_pkg::TableDepth];
  logic [att_pkg::SizeW-1:0]  tbl_size [att_pkg::TableDepth];
  logic                       tbl_live [att_pkg::TableDepth];
  int                         tbl_used;
  logic [att_pkg::CallW-1:0]  n_alloc;
  logic [att_pkg::CallW-1:0]  n_rel_ok;
  logic [att_pkg::CallW-1:0]  n_rel_fail;
  logic [att_pkg::BytesW-1:0] alloc_bytes;
  logic [att_pkg::BytesW-1:0] freed_bytes;

  att_pkg::att_out_t expected_reports [$];
  int                errors = 0;
  int                stall_left = 0;
  bit                idling_on = 1'b1;
  longint            cycles = 0;

  allocation_tracker_table_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [att_pkg::CallW-1:0] count_up(
      input logic [att_pkg::CallW-1:0] v);
    return (&v) ? v : v + {{(att_pkg::CallW-1){1'b0}}, 1'b1};
  endfunction

  function automatic logic [att_pkg::BytesW-1:0] add_bytes(
      input logic [att_pkg::BytesW-1:0] total,
      input logic [att_pkg::SizeW-1:0]  amount);
    logic [att_pkg::BytesW:0] sum;
    sum = {1'b0, total} + {{(att_pkg::BytesW - att_pkg::SizeW + 1){1'b0}}, amount};
    return sum[att_pkg::BytesW] ? {att_pkg::BytesW{1'b1}} : sum[att_pkg::BytesW-1:0];
  endfunction

  function automatic logic [att_pkg::AddrW-1:0] rand_addr();
    logic [att_pkg::AddrW-1:0] a;
    a[att_pkg::AddrW-1:32] = 16'($urandom_range(0, 16'hFFFF));
    a[31:0]                = $urandom();
    return a;
  endfunction

  function automatic att_pkg::att_in_t make_event(input logic op,
                                                  input logic [att_pkg::AddrW-1:0] a,
                                                  input logic [att_pkg::SizeW-1:0] s);
    att_pkg::att_in_t ev;
    ev.opcode     = op;
    ev.address    = a;
    ev.size_bytes = s;
    return ev;
  endfunction

  // Apply one event to the shadow table and return the counter snapshot
  function automatic att_pkg::att_out_t track_event(input att_pkg::att_in_t ev);
    int                   hit_idx;
    att_pkg::att_status_e st;
    att_pkg::att_out_t    res;
    hit_idx = -1;
    for (int i = 0; i < tbl_used; i++) begin
      if (hit_idx < 0 && tbl_addr[i] == ev.address) hit_idx = i;
    end
    if (ev.opcode == att_pkg::OpAlloc) begin
      if (hit_idx >= 0) begin
        tbl_size[hit_idx] = ev.size_bytes;
        tbl_live[hit_idx] = 1'b1;
        n_alloc     = count_up(n_alloc);
        alloc_bytes = add_bytes(alloc_bytes, ev.size_bytes);
        st = att_pkg::ST_REUSED;
      end else if (tbl_used >= att_pkg::TableDepth) begin
        st = att_pkg::ST_FULL;
      end else begin
        tbl_addr[tbl_used] = ev.address;
        tbl_size[tbl_used] = ev.size_bytes;
        tbl_live[tbl_used] = 1'b1;
        tbl_used++;
        n_alloc     = count_up(n_alloc);
        alloc_bytes = add_bytes(alloc_bytes, ev.size_bytes);
        st = att_pkg::ST_NEW;
      end
    end else if (ev.address == '0) begin
      // null release never looks at the table, even if zero was allocated
      n_rel_fail = count_up(n_rel_fail);
      st = att_pkg::ST_NULL;
    end else if (hit_idx < 0) begin
      n_rel_fail = count_up(n_rel_fail);
      st = att_pkg::ST_UNKNOWN;
    end else if (!tbl_live[hit_idx]) begin
      n_rel_fail = count_up(n_rel_fail);
      st = att_pkg::ST_DOUBLE;
    end else begin
      tbl_live[hit_idx] = 1'b0;
      n_rel_ok    = count_up(n_rel_ok);
      freed_bytes = add_bytes(freed_bytes, tbl_size[hit_idx]);
      st = att_pkg::ST_REL_OK;
    end
    res.status               = st;
    res.alloc_calls          = n_alloc;
    res.release_ok_calls     = n_rel_ok;
    res.release_failed_calls = n_rel_fail;
    res.bytes_allocated      = alloc_bytes;
    res.bytes_released       = freed_bytes;
    return res;
  endfunction

  // Drive one input transaction, then record its expected result
  task automatic send_event(input att_pkg::att_in_t ev);
    int gap;
    gap = idling_on ? $urandom_range(0, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    do @(posedge clk_i); while (in_stall_o);
    expected_reports.push_back(track_event(ev));
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= ReportCap)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    att_pkg::att_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= ReportCap)
          $display("%0t: result with none expected, expected nothing, actual status %0d",
                   $time, out_data_o.status);
      end else begin
        want = expected_reports.pop_front();
        check_field("status", 64'(want.status), 64'(out_data_o.status));
        check_field("alloc_calls", 64'(want.alloc_calls), 64'(out_data_o.alloc_calls));
        check_field("release_ok_calls", 64'(want.release_ok_calls),
                    64'(out_data_o.release_ok_calls));
        check_field("release_failed_calls", 64'(want.release_failed_calls),
                    64'(out_data_o.release_failed_calls));
        check_field("bytes_allocated", 64'(want.bytes_allocated),
                    64'(out_data_o.bytes_allocated));
        check_field("bytes_released", 64'(want.bytes_released),
                    64'(out_data_o.bytes_released));
      end
      stall_left = idling_on ? $urandom_range(0, 6) : 0;
    end
  end

  // Receiver stall: holds each result for the drawn number of cycles
  always @(negedge clk_i) begin
    out_stall_i <= (stall_left > 0);
    if (stall_left > 0 && out_valid_o) stall_left--;
  end

  // Each status except full, field extremes, zero address handling
  task automatic test_basic_events();
    send_event(make_event(att_pkg::OpAlloc, TopAddr, '1));        // new entry, largest size
    send_event(make_event(att_pkg::OpRelease, TopAddr, '0));      // release ok
    send_event(make_event(att_pkg::OpRelease, TopAddr, '0));      // double release
    send_event(make_event(att_pkg::OpAlloc, TopAddr, '0));        // reuse with zero size
    send_event(make_event(att_pkg::OpRelease, TopAddr, '1));      // size ignored on release
    send_event(make_event(att_pkg::OpRelease, '0, '1));           // null release
    send_event(make_event(att_pkg::OpRelease, StrayAddr, '0));    // unknown address
    send_event(make_event(att_pkg::OpAlloc, '0, 32'h1));          // zero address is tracked
    send_event(make_event(att_pkg::OpRelease, '0, '0));           // but releasing it is null
    send_event(make_event(att_pkg::OpAlloc, '0, 32'hA5A5_5A5A));  // reuse of zero entry
    send_event(make_event(att_pkg::OpAlloc, TopAddr, 32'h8000_0001));
    send_event(make_event(att_pkg::OpRelease, TopAddr, 32'h7FFF_FFFE));
  endtask

  // Back-to-back allocate/release pairs with near-maximum sizes
  task automatic test_large_sizes();
    logic [att_pkg::SizeW-1:0] amount;
    idling_on = 1'b0;
    for (int n = 0; n < LargePairs; n++) begin
      amount = $urandom();
      amount[att_pkg::SizeW-1:16] = 16'hFFFF;
      send_event(make_event(att_pkg::OpAlloc, TopAddr, amount));
      send_event(make_event(att_pkg::OpRelease, TopAddr, '0));
    end
    idling_on = 1'b1;
  endtask

  // Fill the table, then hit the full case and the last slot
  task automatic test_table_full();
    logic [att_pkg::AddrW-1:0] extra;
    while (tbl_used < att_pkg::TableDepth)
      send_event(make_event(att_pkg::OpAlloc, rand_addr(), $urandom()));
    extra = rand_addr();
    send_event(make_event(att_pkg::OpAlloc, extra, $urandom()));
    send_event(make_event(att_pkg::OpRelease, extra, $urandom()));
    send_event(make_event(att_pkg::OpAlloc, tbl_addr[att_pkg::TableDepth-1], $urandom()));
    send_event(make_event(att_pkg::OpRelease, tbl_addr[att_pkg::TableDepth-1], $urandom()));
  endtask

  // Mostly addresses held in the table, some strangers and some nulls
  task automatic test_random_events();
    logic [att_pkg::AddrW-1:0] extras [8];
    logic [att_pkg::AddrW-1:0] a;
    logic                      op;
    int                        pick;
    foreach (extras[i]) extras[i] = rand_addr();
    for (int n = 0; n < RandomEvents; n++) begin
      if (n % 50 == 0) idling_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 70)      a = tbl_addr[att_pkg::IdxW'($urandom_range(0, tbl_used - 1))];
      else if (pick < 85) a = extras[3'($urandom_range(0, 7))];
      else if (pick < 95) a = rand_addr();
      else                a = '0;
      op = $urandom_range(0, 1) ? att_pkg::OpRelease : att_pkg::OpAlloc;
      send_event(make_event(op, a, $urandom()));
    end
    idling_on = 1'b1;
  endtask

  initial begin
    tbl_used    = 0;
    n_alloc     = '0;
    n_rel_ok    = '0;
    n_rel_fail  = '0;
    alloc_bytes = '0;
    freed_bytes = '0;
    foreach (tbl_live[i]) tbl_live[i] = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_events();
    test_large_sizes();
    test_table_full();
    test_random_events();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
